[hdl/aesc_pkg.sv]
// ----------------------------------------------------------------------------
// aesc_pkg
// types, constants and round functions shared by the aes ecb/cbc core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aesc_pkg;

  localparam int BLOCK_BYTES = 16;
  localparam logic [7:0] GF_REDUCE = 8'h1b;
  localparam logic [3:0] ROUND_BASE = 4'd6;
  localparam int KEY_ROWS = 15;
  localparam int ROW_W = $clog2(KEY_ROWS);

  // configuration register indexes
  localparam logic [2:0] CFG_KEY0     = 3'd0;
  localparam logic [2:0] CFG_KEY1     = 3'd1;
  localparam logic [2:0] CFG_KEY2     = 3'd2;
  localparam logic [2:0] CFG_KEY3     = 3'd3;
  localparam logic [2:0] CFG_KEY_LEN  = 3'd4;
  localparam logic [2:0] CFG_MODE     = 3'd5;
  localparam logic [2:0] CFG_IV_HIGH  = 3'd6;
  localparam logic [2:0] CFG_IV_LOW   = 3'd7;

  typedef struct packed {
    logic key_start;
    logic key_step;
    logic load;
    logic add0;
    logic round;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic key_last;
    logic last_round;
  } status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? GF_REDUCE : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [7:0] gm9(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ a;
  endfunction
  function automatic logic [7:0] gm11(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
  endfunction
  function automatic logic [7:0] gm13(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
  endfunction
  function automatic logic [7:0] gm14(input logic [7:0] a);
    return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
    logic [7:0] a0, a1, a2, a3;
    a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
    return {gm14(a0) ^ gm11(a1) ^ gm13(a2) ^ gm9(a3),
            gm9(a0) ^ gm14(a1) ^ gm11(a2) ^ gm13(a3),
            gm13(a0) ^ gm9(a1) ^ gm14(a2) ^ gm11(a3),
            gm11(a0) ^ gm13(a1) ^ gm9(a2) ^ gm14(a3)};
  endfunction

  // byte k of the state sits at bits 127-8k downto 120-8k
  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] b [16];
    logic [127:0] t;
    logic [127:0] m;
    for (int k = 0; k < 16; k++) b[k] = SBOX[s[127-8*k -: 8]];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = b[4*((c+r)%4)+r];
    for (int c = 0; c < 4; c++) m[127-32*c -: 32] = mix_col(t[127-32*c -: 32]);
    return (last ? t : m) ^ rk;
  endfunction

  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [127:0] m;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(4*c+r) -: 8] = INV_SBOX[s[127-8*(4*((c+3*r)%4)+r) -: 8]];
    t = t ^ rk;
    for (int c = 0; c < 4; c++) m[127-32*c -: 32] = inv_mix_col(t[127-32*c -: 32]);
    return last ? t : m;
  endfunction

  // key words for the key length code, code 3 acts as 256 bits
  function automatic logic [3:0] key_words(input logic [1:0] klen);
    return (klen == 2'd0) ? 4'd4 : ((klen == 2'd1) ? 4'd6 : 4'd8);
  endfunction

endpackage

[hdl/aesc_ram.sv]
// ----------------------------------------------------------------------------
// aesc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aesc_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/aesc_datapath.sv]
// ----------------------------------------------------------------------------
// aesc_datapath
// key expansion, round state, cbc chain and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aesc_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  aesc_pkg::cmd_t        cmd,
  output aesc_pkg::status_t     status,
  input  logic [63:0]           key_word [4],
  input  logic [1:0]            key_length,
  input  logic [1:0]            operation_mode,
  input  logic [63:0]           iv_high,
  input  logic [63:0]           iv_low,
  input  logic [63:0]           block_high,
  input  logic [63:0]           block_low,
  input  logic [4:0]            byte_count,
  input  logic                  first_block,
  output logic [63:0]           result_high,
  output logic [63:0]           result_low,
  output logic [4:0]            result_bytes
);
  import aesc_pkg::*;

  logic        dec, cbc;
  logic [3:0]  nk, nr;
  assign dec = operation_mode[0];
  assign cbc = operation_mode[1];
  assign nk  = key_words(key_length);
  assign nr  = nk + ROUND_BASE;

  // key expansion
  logic [5:0]   kidx;
  logic [2:0]   kmod;
  logic [7:0]   rc;
  logic [31:0]  win [8];
  logic [31:0]  acc [3];
  logic [31:0]  kword, ktmp, kfar;
  logic [5:0]   klast_idx;

  always_comb begin
    kfar = (nk == 4'd4) ? win[3] : ((nk == 4'd6) ? win[5] : win[7]);
    ktmp = win[0];
    if (kmod == 3'd0) begin
      ktmp = sub_word({win[0][23:0], win[0][31:24]}) ^ {rc, 24'h0};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      ktmp = sub_word(win[0]);
    end
    if ({2'b00, kidx} < {4'b0000, nk}) begin
      kword = kidx[0] ? key_word[kidx[2:1]][31:0] : key_word[kidx[2:1]][63:32];
    end else begin
      kword = kfar ^ ktmp;
    end
    klast_idx = 6'({nk, 2'b00} + 6'd27);  // 4*(nk+7)-1
  end

  // round key store, one row of four words per round
  logic              rk_we;
  logic [ROW_W-1:0]  rk_waddr, rk_raddr;
  logic [127:0]      rk_wdata, rk;

  assign rk_we    = cmd.key_step && (kidx[1:0] == 2'd3);
  assign rk_waddr = kidx[5:2];
  assign rk_wdata = {acc[0], acc[1], acc[2], kword};

  aesc_ram #(.WIDTH(128), .DEPTH(KEY_ROWS)) u_rk_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rk_raddr),
    .rdata (rk)
  );

  // round state
  logic [ROW_W-1:0] row, row_start, row_step;
  logic             last;
  logic [127:0]     state, chain_use, in_copy, chain, blk, init, outv;
  logic [4:0]       n, cnt;
  logic [7:0]       pad;
  logic [15:0]      same;

  assign last      = dec ? (row == '0) : (row == nr);
  assign row_start = dec ? nr : '0;
  assign row_step  = last ? row : (dec ? row - 1'b1 : row + 1'b1);
  assign rk_raddr  = cmd.load ? row_start : row_step;
  assign status.last_round = last;
  assign status.key_last   = (kidx == klast_idx);

  always_comb begin
    blk = {block_high, block_low};
    n   = (byte_count > 5'd16) ? 5'd16 : byte_count;
    pad = {3'b000, 5'd16 - n};
    init = blk;
    if (!dec) begin
      for (int i = 0; i < 16; i++)
        if (5'(i) >= n) init[127-8*i -: 8] = pad;
      if (cbc) init = init ^ ((first_block) ? {iv_high, iv_low} : chain);
    end
  end

  // padding scan on the finished block
  always_comb begin
    outv = state ^ ((dec && cbc) ? chain_use : 128'h0);
    same[15] = 1'b1;
    for (int i = 14; i >= 0; i--)
      same[i] = same[i+1] && (outv[127-8*i -: 8] == outv[119-8*i -: 8]);
    cnt = 5'd16;
    if (dec) begin
      for (int i = 15; i >= 0; i--)
        if (same[i] && outv[127-8*i -: 8] == 8'(16 - i)) cnt = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_start) begin
      kidx <= '0;
      kmod <= '0;
      rc   <= 8'h01;
    end
    if (cmd.key_step) begin
      win[0] <= kword;
      for (int k = 1; k < 8; k++) win[k] <= win[k-1];
      if (kidx[1:0] != 2'd3) acc[kidx[1:0]] <= kword;
      kidx <= kidx + 1'b1;
      kmod <= ({1'b0, kmod} == nk - 4'd1) ? 3'd0 : kmod + 1'b1;
      if ({2'b00, kidx} >= {4'b0000, nk} && kmod == 3'd0) rc <= xtime(rc);
    end
    if (cmd.load) begin
      state     <= init;
      in_copy   <= blk;
      chain_use <= first_block ? {iv_high, iv_low} : chain;
      row       <= row_start;
    end
    if (cmd.add0) begin
      state <= state ^ rk;
      row   <= row_step;
    end
    if (cmd.round) begin
      state <= dec ? dec_round(state, rk, last) : enc_round(state, rk, last);
      row   <= row_step;
    end
    if (cmd.fin) begin
      {result_high, result_low} <= outv;
      result_bytes <= cnt;
    end
    if (rst) begin
      chain <= '0;
    end else if (cmd.fin && cbc) begin
      chain <= dec ? in_copy : state;
    end
  end

endmodule

[hdl/aesc_ctrl.sv]
// ----------------------------------------------------------------------------
// aesc_ctrl
// sequencer for key expansion, rounds and output handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aesc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              key_write,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output aesc_pkg::cmd_t    cmd,
  input  aesc_pkg::status_t status
);
  import aesc_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_ADD0   = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   dirty, dirty_next;
  logic   out_valid_next;

  assign in_ready = (state == ST_IDLE) && !dirty;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (dirty) begin
          cmd.key_start = 1'b1;
          state_next    = ST_EXPAND;
        end else if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ADD0;
        end
      end
      ST_EXPAND: begin
        cmd.key_step = 1'b1;
        if (status.key_last) state_next = ST_IDLE;
      end
      ST_ADD0: begin
        cmd.add0   = 1'b1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (status.last_round) state_next = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    dirty_next     = (dirty && !cmd.key_start) || key_write;
    out_valid_next = cmd.fin || (out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dirty     <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      dirty     <= dirty_next;
      out_valid <= out_valid_next;
    end
  end

  a_fin_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> out_valid) else $error("result not presented after finish");
  a_no_load_dirty: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !dirty) else $error("block taken with stale round keys");
  a_round_to_fin: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && status.last_round) |=> state == ST_FIN)
    else $error("last round did not finish");
  a_expand_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXPAND && status.key_last) |=> state == ST_IDLE)
    else $error("key expansion overran");

endmodule

[hdl/aes_block_cipher_ecb_cbc_core.sv]
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_cbc_core
// aes-128/192/256 block encrypt/decrypt in ecb or cbc mode
// ----------------------------------------------------------------------------
// usage:
//  - cfg channel writes keys, key length, mode and iv (cfg_index picks the
//    register); cfg_ready is always high
//  - any key or key length write marks the round keys stale; the core then
//    expands them into the round key ram before it takes the next block;
//    reset also starts an expansion
//  - s_axis carries one 16-byte block per transaction, tuser restarts the
//    cbc chain from the iv
//  - one round per cycle: accept, initial key add, nr rounds (10/12/14),
//    finish; a new block is taken only once the previous one has finished,
//    as there is a single round unit and a cbc chain between blocks
//  - m_axis holds the result in an output register; a new block is accepted
//    while it waits, but the next result stalls in its finish step until the
//    receiver takes the previous one
//  - reset clears the registers, the chain value and the valid flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aes_block_cipher_ecb_cbc_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // block_high [63:0], block_low [127:64], byte_count [132:128], zero fill
  input  logic [135:0] s_axis_tdata,
  // first_block [0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_high [63:0], result_low [127:64], result_bytes [132:128], zero fill
  output logic [135:0] m_axis_tdata
);
  import aesc_pkg::*;

  // configuration registers
  logic [63:0] key_word [4];
  logic [1:0]  key_length;
  logic [1:0]  operation_mode;
  logic [63:0] iv_high, iv_low;
  logic        cfg_write, key_write;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  // keys and key length feed the expansion, mode and iv do not
  assign key_write = cfg_write && (cfg_index != CFG_MODE) && (cfg_index != CFG_IV_HIGH)
                     && (cfg_index != CFG_IV_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
      key_length     <= '0;
      operation_mode <= '0;
      iv_high        <= '0;
      iv_low         <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_KEY0:    key_word[0]    <= cfg_data;
        CFG_KEY1:    key_word[1]    <= cfg_data;
        CFG_KEY2:    key_word[2]    <= cfg_data;
        CFG_KEY3:    key_word[3]    <= cfg_data;
        CFG_KEY_LEN: key_length     <= cfg_data[1:0];
        CFG_MODE:    operation_mode <= cfg_data[1:0];
        CFG_IV_HIGH: iv_high        <= cfg_data;
        CFG_IV_LOW:  iv_low         <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_t        cmd;
  status_t     status;
  logic [63:0] result_high, result_low;
  logic [4:0]  result_bytes;

  aesc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_write (key_write),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd),
    .status    (status)
  );

  aesc_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .key_word       (key_word),
    .key_length     (key_length),
    .operation_mode (operation_mode),
    .iv_high        (iv_high),
    .iv_low         (iv_low),
    .block_high     (s_axis_tdata[63:0]),
    .block_low      (s_axis_tdata[127:64]),
    .byte_count     (s_axis_tdata[132:128]),
    .first_block    (s_axis_tuser),
    .result_high    (result_high),
    .result_low     (result_low),
    .result_bytes   (result_bytes)
  );

  assign m_axis_tdata = {3'b000, result_bytes, result_low, result_high};

endmodule
